[rtl/skld_pkg.sv]
// Shared types and constants for the symmetric KL divergence core.
package skld_pkg;

	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [63:0] TWO_Q16  = 64'h0000_0000_0002_0000;
	localparam logic [31:0] ONE_RAW  = 32'd1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SQ   = 6'b000010,
		S_DIV  = 6'b000100,
		S_TERM = 6'b001000,
		S_SUM  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_R1  = 3'd0,
		OP_R2  = 3'd1,
		OP_Q1  = 3'd2,
		OP_Q2  = 3'd3,
		OP_AVG = 3'd4
	} op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/skld_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface skld_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mean_a;
	logic signed [31:0] mean_b;
	logic        [31:0] var_a;
	logic        [31:0] var_b;
	logic               last_dim;

	modport source (output valid, mean_a, mean_b, var_a, var_b, last_dim, input ready);
	modport sink   (input valid, mean_a, mean_b, var_a, var_b, last_dim, output ready);
endinterface

interface skld_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] divergence;
	logic        saturated;

	modport source (output valid, divergence, saturated, input ready);
	modport sink   (input valid, divergence, saturated, output ready);
endinterface

[rtl/skld_div.sv]
// Iterative radix-2 restoring divider: 64-bit dividend by 32-bit divisor.
module skld_div import skld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output div_status_t status,
	output logic [63:0] quotient
);

	logic [63:0]          dvd_q;
	logic [31:0]          rem_q;
	logic [31:0]          div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic        ge;

	always_comb begin
		rem_sh = {rem_q, dvd_q[63]};
		diff   = {1'b0, rem_sh} - {2'b00, div_q};
		ge     = ~diff[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

[rtl/symmetric_kl_diag_gaussian_core.sv]
// Symmetric KL divergence of diagonal Gaussians, one dimension per input beat.
//
// Channels: "item" takes one dimension per beat (means signed Q16.16,
// variances unsigned Q16.16, last_dim). "result" gives one beat per item
// marked last: the Q32.16 score and a saturation flag. dim_divisor_we and
// dim_divisor_wdata write the dimension count; the user must write it only
// while the core is idle, as the block itself does not enforce it.
// Each item runs four divisions (two variance ratios, two squared-distance
// quotients) through one shared radix-2 divider; item.ready is low meanwhile.
// An item not marked last returns the core to idle, raising item.ready,
// once its term is added to the accumulator. An item marked last adds one
// more division of the sum by dim_divisor before its result beat appears.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver still stalls when the next score is ready, the
// core holds that score internally and takes no new item until it is sent.
// Reset clears the accumulator, the overflow flag and any pending result,
// and sets dim_divisor to 1.
module symmetric_kl_diag_gaussian_core import skld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	skld_in_if.sink     item,
	skld_out_if.source  result,
	input  logic        dim_divisor_we,
	input  logic [7:0]  dim_divisor_wdata
);

	state_t      state_q;
	op_t         op_q;
	logic [7:0]  dim_divisor_q;

	logic [31:0] ad_q;
	logic [31:0] va_q;
	logic [31:0] vb_q;
	logic        last_q;
	logic [63:0] dsq_q;
	logic [63:0] s_q;
	logic        s_ovf_q;
	logic [63:0] term_q;
	logic [63:0] term_sum_q;
	logic        overflow_seen_q;
	logic        fin_ovf_q;
	logic [63:0] avg_q;

	logic        out_valid_q;
	logic [47:0] out_div_q;
	logic        out_sat_q;

	logic        div_start;
	logic [63:0] div_dividend;
	logic [31:0] div_divisor;
	div_status_t div_status;
	logic [63:0] div_quo;

	logic        accept;
	logic [32:0] d;
	logic [32:0] d_abs;
	logic [64:0] s_sum;
	logic [63:0] s_next;
	logic        s_carry;
	logic [64:0] acc_sum;
	logic [63:0] acc_next;
	logic        acc_carry;
	logic        out_free;

	skld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.status   (div_status),
		.quotient (div_quo)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	always_comb begin
		d     = {item.mean_a[31], item.mean_a} - {item.mean_b[31], item.mean_b};
		d_abs = d[32] ? (~d + 33'd1) : d;
		s_sum     = {1'b0, s_q} + {1'b0, div_quo};
		s_carry   = s_sum[64];
		s_next    = s_carry ? '1 : s_sum[63:0];
		acc_sum   = {1'b0, term_sum_q} + {1'b0, term_q};
		acc_carry = acc_sum[64];
		acc_next  = acc_carry ? '1 : acc_sum[63:0];
	end

	// select the next division and its operands
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {16'h0000, va_q, 16'h0000};
		div_divisor  = vb_q;
		case (state_q)
			S_SQ: begin
				div_start = 1'b1;
			end
			S_DIV: begin
				if (div_status.done) begin
					case (op_q)
						OP_R1: begin
							div_start    = 1'b1;
							div_dividend = {16'h0000, vb_q, 16'h0000};
							div_divisor  = va_q;
						end
						OP_R2: begin
							div_start    = 1'b1;
							div_dividend = dsq_q;
							div_divisor  = va_q;
						end
						OP_Q1: begin
							div_start    = 1'b1;
							div_dividend = dsq_q;
							div_divisor  = vb_q;
						end
						default: begin
						end
					endcase
				end
			end
			S_SUM: begin
				if (last_q) begin
					div_start    = 1'b1;
					div_dividend = acc_next;
					div_divisor  = (dim_divisor_q == 8'd0) ? ONE_RAW
					                                      : {24'h000000, dim_divisor_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_q            <= OP_R1;
			dim_divisor_q   <= 8'd1;
			term_sum_q      <= '0;
			overflow_seen_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (dim_divisor_we) begin
				dim_divisor_q <= dim_divisor_wdata;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					op_q    <= OP_R1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_status.done) begin
						case (op_q)
							OP_R1:   op_q <= OP_R2;
							OP_R2:   op_q <= OP_Q1;
							OP_Q1:   op_q <= OP_Q2;
							OP_Q2:   state_q <= S_TERM;
							OP_AVG:  state_q <= S_OUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_TERM: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (last_q) begin
						term_sum_q      <= '0;
						overflow_seen_q <= 1'b0;
						op_q            <= OP_AVG;
						state_q         <= S_DIV;
					end else begin
						term_sum_q      <= acc_next;
						overflow_seen_q <= overflow_seen_q | s_ovf_q | acc_carry;
						state_q         <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ad_q   <= d_abs[31:0];
			va_q   <= (item.var_a == 32'd0) ? ONE_RAW : item.var_a;
			vb_q   <= (item.var_b == 32'd0) ? ONE_RAW : item.var_b;
			last_q <= item.last_dim;
		end
		if (state_q == S_SQ) begin
			dsq_q   <= ad_q * ad_q;
			s_q     <= '0;
			s_ovf_q <= 1'b0;
		end
		if (state_q == S_DIV && div_status.done) begin
			if (op_q == OP_AVG) begin
				avg_q <= div_quo;
			end else begin
				s_q     <= s_next;
				s_ovf_q <= s_ovf_q | s_carry;
			end
		end
		if (state_q == S_TERM) begin
			term_q <= (s_q >= TWO_Q16) ? {2'b00, s_q[63:2] - TWO_Q16[63:2]} : '0;
		end
		if (state_q == S_SUM) begin
			fin_ovf_q <= overflow_seen_q | s_ovf_q | acc_carry;
		end
		if (state_q == S_OUT && out_free) begin
			out_div_q <= (avg_q[63:48] != 16'h0000) ? '1 : avg_q[47:0];
			out_sat_q <= fin_ovf_q | (avg_q[63:48] != 16'h0000);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.divergence = out_div_q;
	assign result.saturated  = out_sat_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SQ))
		else $error("accepted beat did not start the sequence");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_status.busy)
		else $error("divider busy while idle");

	a_out_written: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (result.valid && state_q == S_IDLE))
		else $error("result not presented after completion");
`endif

endmodule
